// ----- rtl/cdq_pkg.sv -----
// cdq_pkg: shared constants and types for the circular deque
// field widths, operation and status codes, controller/datapath link structs
// no dependencies
package cdq_pkg;

  localparam int OP_W       = 2;
  localparam int VAL_W      = 32;
  localparam int STAT_W     = 2;
  localparam int CFG_W      = 7;
  localparam int CNT_OUT_W  = 7;
  localparam int IN_TDATA_W = 32;
  localparam int OUT_TDATA_W = 112;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd0;
  localparam logic [OP_W-1:0] OP_PUSH_REAR  = 2'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 2'd2;
  localparam logic [OP_W-1:0] OP_POP_REAR   = 2'd3;

  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic exec;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic need_read;
  } sts_t;

endpackage

// ----- rtl/cdq_ctrl.sv -----
// cdq_ctrl: sequencer for the circular deque, one item at a time
// issues execute and load commands to cdq_dpath, drives the handshakes
// depends on cdq_pkg
module cdq_ctrl (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  cdq_pkg::sts_t sts,
  output cdq_pkg::cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign cmd.exec   = in_tvalid && in_tready;
  assign cmd.load   = (state_r == S_READ);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.exec) begin
          state_nxt = sts.need_read ? S_READ : S_OUT;
        end
      end
      S_READ: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/cdq_dpath.sv -----
// cdq_dpath: ring store, pointers, count and cached end values of the deque
// executes one operation per exec command, refills an end value on load
// depends on cdq_pkg
module cdq_dpath #(
  parameter int MAX_ENTRIES = 64,
  parameter int DATA_BITS   = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  cdq_pkg::cmd_t                    cmd,
  output cdq_pkg::sts_t                    sts,
  input  logic [cdq_pkg::OP_W-1:0]         op,
  input  logic [cdq_pkg::VAL_W-1:0]        value_in,
  input  logic                             cfg_wr_en,
  input  logic [cdq_pkg::CFG_W-1:0]        cfg_wr_data,
  output logic [cdq_pkg::STAT_W-1:0]       status,
  output logic [cdq_pkg::VAL_W-1:0]        popped_value,
  output logic [cdq_pkg::VAL_W-1:0]        front_value,
  output logic [cdq_pkg::VAL_W-1:0]        rear_value,
  output logic                             is_empty,
  output logic                             is_full,
  output logic [cdq_pkg::CNT_OUT_W-1:0]    entry_count
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CAP_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (CAP_W > cdq_pkg::CFG_W) ? CAP_W : cdq_pkg::CFG_W;

  logic [DATA_BITS-1:0] mem [MAX_ENTRIES];
  logic [DATA_BITS-1:0] rd_data_r;

  logic [IDX_W-1:0]     front_idx_r, front_idx_nxt;
  logic [IDX_W-1:0]     rear_idx_r, rear_idx_nxt;
  logic [CAP_W-1:0]     count_r, count_nxt;
  logic [CAP_W-1:0]     cap_r, cap_nxt;
  logic                 empty_r, empty_nxt;
  logic [DATA_BITS-1:0] front_val_r, front_val_nxt;
  logic [DATA_BITS-1:0] rear_val_r, rear_val_nxt;
  logic [cdq_pkg::STAT_W-1:0] status_r, status_nxt;
  logic [DATA_BITS-1:0] popped_r, popped_nxt;
  logic                 refill_front_r, refill_front_nxt;

  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [IDX_W-1:0]     rd_addr;
  logic [DATA_BITS-1:0] v_ext;
  logic [IDX_W-1:0]     front_dec, front_inc, rear_dec, rear_inc;
  logic [CMP_W-1:0]     cfg_ext;
  logic                 is_push;

  assign v_ext   = DATA_BITS'(value_in);
  assign cfg_ext = CMP_W'(cfg_wr_data);
  assign is_push = (op == cdq_pkg::OP_PUSH_FRONT) || (op == cdq_pkg::OP_PUSH_REAR);

  // ring step with wrap at the configured capacity
  assign front_dec = (front_idx_r == '0) ? IDX_W'(cap_r - 1'b1) : front_idx_r - 1'b1;
  assign rear_dec  = (rear_idx_r == '0) ? IDX_W'(cap_r - 1'b1) : rear_idx_r - 1'b1;
  assign front_inc = ((CAP_W+1)'(front_idx_r) + 1'b1 >= (CAP_W+1)'(cap_r)) ? '0
                   : front_idx_r + 1'b1;
  assign rear_inc  = ((CAP_W+1)'(rear_idx_r) + 1'b1 >= (CAP_W+1)'(cap_r)) ? '0
                   : rear_idx_r + 1'b1;

  always_comb begin
    front_idx_nxt    = front_idx_r;
    rear_idx_nxt     = rear_idx_r;
    count_nxt        = count_r;
    cap_nxt          = cap_r;
    empty_nxt        = empty_r;
    front_val_nxt    = front_val_r;
    rear_val_nxt     = rear_val_r;
    status_nxt       = status_r;
    popped_nxt       = popped_r;
    refill_front_nxt = refill_front_r;
    wr_en            = 1'b0;
    wr_addr          = front_idx_r;
    rd_addr          = front_idx_r;
    sts.need_read    = 1'b0;

    if (cmd.exec) begin
      status_nxt = cdq_pkg::STAT_DONE;
      popped_nxt = '0;
      if (is_push) begin
        if (count_r >= cap_r) begin
          status_nxt = cdq_pkg::STAT_FULL;
        end else if (empty_r) begin
          front_idx_nxt = '0;
          rear_idx_nxt  = '0;
          empty_nxt     = 1'b0;
          count_nxt     = CAP_W'(1);
          front_val_nxt = v_ext;
          rear_val_nxt  = v_ext;
          wr_en         = 1'b1;
          wr_addr       = '0;
        end else if (op == cdq_pkg::OP_PUSH_FRONT) begin
          front_idx_nxt = front_dec;
          count_nxt     = count_r + 1'b1;
          front_val_nxt = v_ext;
          wr_en         = 1'b1;
          wr_addr       = front_dec;
        end else begin
          rear_idx_nxt  = rear_inc;
          count_nxt     = count_r + 1'b1;
          rear_val_nxt  = v_ext;
          wr_en         = 1'b1;
          wr_addr       = rear_inc;
        end
      end else if (empty_r) begin
        status_nxt = cdq_pkg::STAT_EMPTY;
      end else begin
        count_nxt = count_r - 1'b1;
        if (op == cdq_pkg::OP_POP_FRONT) begin
          popped_nxt = front_val_r;
        end else begin
          popped_nxt = rear_val_r;
        end
        if (count_r == CAP_W'(1)) begin
          empty_nxt = 1'b1;
        end else if (op == cdq_pkg::OP_POP_FRONT) begin
          front_idx_nxt    = front_inc;
          rd_addr          = front_inc;
          refill_front_nxt = 1'b1;
          sts.need_read    = 1'b1;
        end else begin
          rear_idx_nxt     = rear_dec;
          rd_addr          = rear_dec;
          refill_front_nxt = 1'b0;
          sts.need_read    = 1'b1;
        end
      end
    end

    if (cmd.load) begin
      if (refill_front_r) begin
        front_val_nxt = rd_data_r;
      end else begin
        rear_val_nxt = rd_data_r;
      end
    end

    // capacity only moves while empty; out-of-range values clamp
    if (cfg_wr_en && empty_r) begin
      if (cfg_ext == '0) begin
        cap_nxt = CAP_W'(1);
      end else if (cfg_ext > CMP_W'(MAX_ENTRIES)) begin
        cap_nxt = CAP_W'(MAX_ENTRIES);
      end else begin
        cap_nxt = CAP_W'(cfg_ext);
      end
      front_idx_nxt = '0;
      rear_idx_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= v_ext;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_idx_r <= '0;
      rear_idx_r  <= '0;
      count_r     <= '0;
      cap_r       <= CAP_W'(MAX_ENTRIES);
      empty_r     <= 1'b1;
    end else begin
      front_idx_r <= front_idx_nxt;
      rear_idx_r  <= rear_idx_nxt;
      count_r     <= count_nxt;
      cap_r       <= cap_nxt;
      empty_r     <= empty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    front_val_r    <= front_val_nxt;
    rear_val_r     <= rear_val_nxt;
    status_r       <= status_nxt;
    popped_r       <= popped_nxt;
    refill_front_r <= refill_front_nxt;
  end

  assign status       = status_r;
  assign popped_value = cdq_pkg::VAL_W'(popped_r);
  assign front_value  = empty_r ? '0 : cdq_pkg::VAL_W'(front_val_r);
  assign rear_value   = empty_r ? '0 : cdq_pkg::VAL_W'(rear_val_r);
  assign is_empty     = empty_r;
  assign is_full      = (count_r == cap_r);
  assign entry_count  = cdq_pkg::CNT_OUT_W'(count_r);

`ifndef SYNTHESIS
  a_count_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cap_r) else $error("entry count above capacity");

  a_empty_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    empty_r == (count_r == '0)) else $error("empty flag disagrees with count");

  a_reject_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && (status_nxt != cdq_pkg::STAT_DONE) |=> $stable(count_r))
    else $error("rejected item changed the count");

  a_cap_stable_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !empty_r |=> $stable(cap_r)) else $error("capacity changed while holding items");
`endif

endmodule

// ----- rtl/circular_deque.sv -----
// circular_deque: double-ended queue on a ring store with configurable capacity
// result: valid in the cycle after accept; a pop that leaves items passes through S_READ first
// items are handled one at a time: a new item is accepted only after the result is taken
// and after the store's registered read port has refilled the new end value after a pop
// reset: pointers to entry 0, deque empty, capacity MAX_ENTRIES; store not cleared
// depends on cdq_pkg, cdq_ctrl, cdq_dpath
module circular_deque #(
  parameter int MAX_ENTRIES = 64,
  parameter int DATA_BITS   = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // value_in[31:0]
  input  logic [cdq_pkg::IN_TDATA_W-1:0]      in_tdata,
  // operation[1:0]
  input  logic [cdq_pkg::OP_W-1:0]            in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // popped_value[31:0], front_value[63:32], rear_value[95:64], is_empty[96],
  // is_full[97], entry_count[104:98], zero[111:105]
  output logic [cdq_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // status[1:0]
  output logic [cdq_pkg::STAT_W-1:0]          out_tuser,
  input  logic                                cfg_wr_en,
  input  logic [cdq_pkg::CFG_W-1:0]           cfg_wr_data
);

  cdq_pkg::cmd_t cmd;
  cdq_pkg::sts_t sts;

  logic [cdq_pkg::VAL_W-1:0]     popped_value;
  logic [cdq_pkg::VAL_W-1:0]     front_value;
  logic [cdq_pkg::VAL_W-1:0]     rear_value;
  logic                          is_empty;
  logic                          is_full;
  logic [cdq_pkg::CNT_OUT_W-1:0] entry_count;

  cdq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  cdq_dpath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .DATA_BITS   (DATA_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .op           (in_tuser),
    .value_in     (in_tdata),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .status       (out_tuser),
    .popped_value (popped_value),
    .front_value  (front_value),
    .rear_value   (rear_value),
    .is_empty     (is_empty),
    .is_full      (is_full),
    .entry_count  (entry_count)
  );

  assign out_tdata = {7'd0, entry_count, is_full, is_empty,
                      rear_value, front_value, popped_value};

endmodule

// ----- dv/circular_deque_test.sv -----
`timescale 1ns / 100ps
// circular_deque_test: self-checking bench for the circular deque, with an item
// driver, a result monitor and a deque predictor kept in step with the block
// depends on cdq_pkg and circular_deque
module circular_deque_test;

  localparam int MAX_ENTRIES   = 64;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 10;
  localparam int CYCLE_LIMIT   = 600000;

  typedef enum logic [1:0] {REQ_ITEM, REQ_CFG, REQ_DRAIN} req_kind_t;

  typedef struct {
    req_kind_t                 kind;
    logic [cdq_pkg::OP_W-1:0]  op;
    logic [cdq_pkg::VAL_W-1:0] value;
    logic [cdq_pkg::CFG_W-1:0] cfg_value;
    int                        gap;
  } deque_req_t;

  typedef struct {
    logic [cdq_pkg::STAT_W-1:0]    status;
    logic [cdq_pkg::VAL_W-1:0]     popped;
    logic [cdq_pkg::VAL_W-1:0]     front;
    logic [cdq_pkg::VAL_W-1:0]     rear;
    logic                          empty;
    logic                          full;
    logic [cdq_pkg::CNT_OUT_W-1:0] count;
  } deque_result_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [cdq_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic [cdq_pkg::OP_W-1:0]        in_tuser = cdq_pkg::OP_PUSH_FRONT;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [cdq_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [cdq_pkg::STAT_W-1:0]      out_tuser;
  logic                            cfg_wr_en = 1'b0;
  logic [cdq_pkg::CFG_W-1:0]       cfg_wr_data = '0;

  deque_req_t    pending_reqs[$];
  deque_result_t expected_results[$];

  // predictor state
  logic [cdq_pkg::VAL_W-1:0] dq_store [MAX_ENTRIES];
  int dq_front, dq_rear, dq_cap;
  bit dq_empty;

  // stimulus build shadow
  int  b_cap = MAX_ENTRIES;
  int  b_cnt = 0;
  bit  calm_in = 1'b0;
  int  total_items = 0;

  int  accepted_items = 0;
  int  error_count = 0;
  int  cycle_count = 0;
  int  quiet_cycles = 0;
  bit  in_fired = 1'b0;
  int  gap_left = 0;
  int  stall_left = 0;
  bit  calm_out = 1'b0;

  circular_deque #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .DATA_BITS  (cdq_pkg::VAL_W)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  function automatic int clamp_capacity(input logic [cdq_pkg::CFG_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > MAX_ENTRIES) return MAX_ENTRIES;
    return int'(raw);
  endfunction

  function automatic int held_entries();
    if (dq_empty) return 0;
    return ((dq_rear + dq_cap - dq_front) % dq_cap) + 1;
  endfunction

  function automatic void deque_configure(input logic [cdq_pkg::CFG_W-1:0] raw);
    if (!dq_empty) return;
    dq_cap = clamp_capacity(raw);
    dq_front = 0;
    dq_rear = 0;
  endfunction

  function automatic deque_result_t deque_apply(input logic [cdq_pkg::OP_W-1:0] op,
                                                input logic [cdq_pkg::VAL_W-1:0] val);
    deque_result_t r;
    r.status = cdq_pkg::STAT_DONE;
    r.popped = '0;
    if (op == cdq_pkg::OP_PUSH_FRONT || op == cdq_pkg::OP_PUSH_REAR) begin
      if (held_entries() >= dq_cap) begin
        r.status = cdq_pkg::STAT_FULL;
      end else if (dq_empty) begin
        dq_front = 0;
        dq_rear = 0;
        dq_empty = 1'b0;
        dq_store[0] = val;
      end else if (op == cdq_pkg::OP_PUSH_FRONT) begin
        dq_front = (dq_front == 0) ? dq_cap - 1 : dq_front - 1;
        dq_store[dq_front] = val;
      end else begin
        dq_rear = (dq_rear + 1 >= dq_cap) ? 0 : dq_rear + 1;
        dq_store[dq_rear] = val;
      end
    end else if (dq_empty) begin
      r.status = cdq_pkg::STAT_EMPTY;
    end else if (op == cdq_pkg::OP_POP_FRONT) begin
      r.popped = dq_store[dq_front];
      if (dq_front == dq_rear) dq_empty = 1'b1;
      else dq_front = (dq_front + 1 >= dq_cap) ? 0 : dq_front + 1;
    end else begin
      r.popped = dq_store[dq_rear];
      if (dq_front == dq_rear) dq_empty = 1'b1;
      else dq_rear = (dq_rear == 0) ? dq_cap - 1 : dq_rear - 1;
    end
    r.front = dq_empty ? '0 : dq_store[dq_front];
    r.rear  = dq_empty ? '0 : dq_store[dq_rear];
    r.empty = dq_empty;
    r.full  = (held_entries() == dq_cap);
    r.count = cdq_pkg::CNT_OUT_W'(held_entries());
    return r;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic [cdq_pkg::VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 1) ? 32'h0000_0000 : 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_item(input logic [cdq_pkg::OP_W-1:0] op,
                          input logic [cdq_pkg::VAL_W-1:0] val);
    deque_req_t req;
    req.kind = REQ_ITEM;
    req.op = op;
    req.value = val;
    req.cfg_value = '0;
    req.gap = calm_in ? 0 : pick_gap();
    pending_reqs.push_back(req);
    total_items++;
    if (op == cdq_pkg::OP_PUSH_FRONT || op == cdq_pkg::OP_PUSH_REAR) begin
      if (b_cnt < b_cap) b_cnt++;
    end else if (b_cnt > 0) begin
      b_cnt--;
    end
  endtask

  task automatic add_cfg(input logic [cdq_pkg::CFG_W-1:0] raw, input req_kind_t kind);
    deque_req_t req;
    req.kind = kind;
    req.op = cdq_pkg::OP_PUSH_FRONT;
    req.value = '0;
    req.cfg_value = raw;
    req.gap = 0;
    pending_reqs.push_back(req);
    if (kind == REQ_CFG && b_cnt == 0) b_cap = clamp_capacity(raw);
  endtask

  task automatic add_empty_out();
    while (b_cnt > 0)
      add_item($urandom_range(0, 1) ? cdq_pkg::OP_POP_FRONT : cdq_pkg::OP_POP_REAR,
               $urandom);
  endtask

  task automatic add_segment(input int len, input int push_pct);
    logic [cdq_pkg::OP_W-1:0] op;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < push_pct)
        op = $urandom_range(0, 1) ? cdq_pkg::OP_PUSH_FRONT : cdq_pkg::OP_PUSH_REAR;
      else
        op = $urandom_range(0, 1) ? cdq_pkg::OP_POP_FRONT : cdq_pkg::OP_POP_REAR;
      add_item(op, pick_value());
    end
  endtask

  // item driver and result back-pressure
  always @(negedge clk) begin : drive
    logic nxt_valid;
    logic nxt_en;
    deque_req_t req;
    nxt_valid = in_tvalid;
    nxt_en = 1'b0;
    if (rst_n) begin
      if (in_tvalid && in_fired) nxt_valid = 1'b0;
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() > 0) begin
          req = pending_reqs[0];
          if (req.kind == REQ_ITEM) begin
            void'(pending_reqs.pop_front());
            nxt_valid = 1'b1;
            in_tuser <= req.op;
            in_tdata <= req.value;
            gap_left = req.gap;
          end else if (expected_results.size() == 0 && quiet_cycles >= SETTLE_CYCLES) begin
            void'(pending_reqs.pop_front());
            if (req.kind == REQ_CFG) begin
              nxt_en = 1'b1;
              cfg_wr_data <= req.cfg_value;
            end
          end
        end
      end
      if ($urandom_range(0, 299) == 0) calm_out = !calm_out;
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if (!calm_out && $urandom_range(0, 99) < 25) stall_left = pick_gap();
      end
    end
    in_tvalid <= nxt_valid;
    cfg_wr_en <= nxt_en;
  end

  task automatic check_field(input string name, input logic [cdq_pkg::VAL_W-1:0] want,
                             input logic [cdq_pkg::VAL_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      error_count++;
    end
  endtask

  // result monitor and predictor update
  always @(posedge clk) begin : monitor
    deque_result_t want;
    if (!rst_n) begin
      dq_front = 0;
      dq_rear = 0;
      dq_empty = 1'b1;
      dq_cap = MAX_ENTRIES;
      in_fired = 1'b0;
      quiet_cycles = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %h data %h",
                   $time, out_tuser, out_tdata);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", cdq_pkg::VAL_W'(want.status),
                      cdq_pkg::VAL_W'(out_tuser));
          check_field("popped_value", want.popped, out_tdata[31:0]);
          check_field("front_value", want.front, out_tdata[63:32]);
          check_field("rear_value", want.rear, out_tdata[95:64]);
          check_field("is_empty", cdq_pkg::VAL_W'(want.empty),
                      cdq_pkg::VAL_W'(out_tdata[96]));
          check_field("is_full", cdq_pkg::VAL_W'(want.full),
                      cdq_pkg::VAL_W'(out_tdata[97]));
          check_field("entry_count", cdq_pkg::VAL_W'(want.count),
                      cdq_pkg::VAL_W'(out_tdata[104:98]));
        end
      end
      if (cfg_wr_en) deque_configure(cfg_wr_data);
      in_fired = in_tvalid && in_tready;
      if (in_fired) begin
        expected_results.push_back(deque_apply(in_tuser, in_tdata));
        accepted_items++;
      end
      if (expected_results.size() == 0 && !in_tvalid) quiet_cycles++;
      else quiet_cycles = 0;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int caps[12];
    int phase_items;
    int start_total;
    caps = '{2, 5, 64, 1, 3, 17, 127, 8, 33, 100, 4, 64};

    // pops on empty, pushes of extreme values at both ends
    add_item(cdq_pkg::OP_POP_FRONT, $urandom);
    add_item(cdq_pkg::OP_POP_REAR, $urandom);
    add_item(cdq_pkg::OP_PUSH_FRONT, 32'h7fff_ffff);
    add_item(cdq_pkg::OP_PUSH_REAR, 32'h8000_0000);
    add_item(cdq_pkg::OP_PUSH_FRONT, 32'h0000_0000);
    add_item(cdq_pkg::OP_PUSH_REAR, 32'hffff_ffff);
    add_item(cdq_pkg::OP_PUSH_FRONT, 32'h5555_5555);
    add_item(cdq_pkg::OP_PUSH_REAR, 32'haaaa_aaaa);
    // capacity write while holding entries is dropped
    add_cfg(7'd3, REQ_CFG);
    add_item(cdq_pkg::OP_POP_FRONT, $urandom);
    add_item(cdq_pkg::OP_POP_REAR, $urandom);
    add_item(cdq_pkg::OP_POP_FRONT, $urandom);
    add_item(cdq_pkg::OP_POP_REAR, $urandom);
    add_item(cdq_pkg::OP_POP_FRONT, $urandom);
    add_item(cdq_pkg::OP_POP_REAR, $urandom);
    add_item(cdq_pkg::OP_POP_REAR, $urandom);
    // zero capacity taken as one
    add_cfg(7'd0, REQ_CFG);
    add_item(cdq_pkg::OP_PUSH_REAR, 32'h1234_5678);
    add_item(cdq_pkg::OP_PUSH_FRONT, $urandom);
    add_item(cdq_pkg::OP_PUSH_REAR, $urandom);
    add_item(cdq_pkg::OP_POP_FRONT, $urandom);
    add_item(cdq_pkg::OP_PUSH_FRONT, 32'hedcb_a987);
    add_item(cdq_pkg::OP_POP_REAR, $urandom);

    foreach (caps[p]) begin
      if ($urandom_range(0, 3) == 0) add_cfg(7'($urandom_range(0, 127)), REQ_CFG);
      add_empty_out();
      add_cfg(7'(caps[p]), REQ_CFG);
      start_total = total_items;
      if (b_cap >= 33) begin
        calm_in = 1'b0;
        add_segment(b_cap + 3, 100);
      end
      phase_items = 0;
      while (total_items - start_total < 80) begin
        calm_in = ($urandom_range(0, 4) == 0);
        case ($urandom_range(0, 4))
          0: add_segment($urandom_range(4, 30), 100);
          1: add_segment($urandom_range(4, 30), 85);
          2: add_segment($urandom_range(4, 30), 50);
          3: add_segment($urandom_range(4, 30), 15);
          default: add_segment($urandom_range(4, 30), 0);
        endcase
        phase_items++;
        if (phase_items == 2) add_cfg('0, REQ_DRAIN);
      end
    end
    calm_in = 1'b0;
    add_empty_out();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (accepted_items < total_items || expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/cdq_pkg.sv
rtl/cdq_ctrl.sv
rtl/cdq_dpath.sv
rtl/circular_deque.sv
dv/circular_deque_test.sv
